// ===== rtl/lcb_pkg.sv =====
// Shared types and constants for the LRU cache with byte budget.
// No dependencies; used by every module under rtl/.
`default_nettype none
package lcb_pkg;

  localparam int unsigned ENTRIES_DEF  = 64;
  localparam logic [31:0] BUDGET_RESET = 32'd16777216;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned COUNT_W      = 7;

  typedef enum logic [1:0] {
    OP_HAS = 2'd0,
    OP_GET = 2'd1,
    OP_PUT = 2'd2,
    OP_ALT = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [31:0] image_size;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [31:0]        entry_size;
    logic [COUNT_W-1:0] entry_count;
    logic [31:0]        total_bytes;
    logic [COUNT_W-1:0] evictions;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [31:0] size;
    logic [63:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic lru_mode;
  } scan_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lru_cache_with_byte_budget_core.sv =====
// Top level: LRU cache of 128-bit keys under a byte budget, sequencer plus
// entry store and scan unit. Depends on lcb_pkg, lcb_mem, lcb_scan.
//
//  channel | ports                         | word
//  --------+-------------------------------+----------------------------
//  in      | in_valid, in_stall, in_data   | lcb_pkg::req_t request
//  out     | out_valid, out_stall, out_data| lcb_pkg::rsp_t result
//  cfg     | cfg_we, cfg_wdata             | byte budget, 32 bits
//
// One request at a time. A table scan reads one slot per cycle from the
// entry store. has, get and alt: one lookup scan. put: none if the size
// exceeds the budget, else one lookup scan and, on a miss, one LRU scan per
// eviction, plus a free-slot search of up to ENTRIES slots unless an
// eviction freed the slot. Synchronous active-low reset clears valid bits,
// the stamp clock, entry count and byte total, and reloads the default budget.
// in_stall is high from acceptance until the result word is taken.
`default_nettype none
module lru_cache_with_byte_budget_core #(
  parameter int unsigned ENTRIES = lcb_pkg::ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lcb_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lcb_pkg::rsp_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_LOOK  = 10'b0000000100,
    S_LDONE = 10'b0000001000,
    S_FIT   = 10'b0000010000,
    S_EVSC  = 10'b0000100000,
    S_EVICT = 10'b0001000000,
    S_FREE  = 10'b0010000000,
    S_WRITE = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // request and architectural state
  lcb_pkg::req_t    req_r;
  logic [31:0]      budget_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [63:0]      clock_r, clock_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      bytes_r, bytes_nxt;
  logic [CNT_W-1:0] evict_r, evict_nxt;

  // result fields under construction
  logic             status_r, status_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [31:0]      esize_r, esize_nxt;
  logic             insert_r, insert_nxt;   // write is a new entry, not a touch
  logic             full_ev_r, full_ev_nxt; // eviction made to free a slot

  // scan sequencing
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             run_r, run_nxt;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic             scan_last;

  lcb_pkg::scan_ctl_t ctl;
  lcb_pkg::entry_t    rd_data;
  lcb_pkg::entry_t    wr_data;
  logic               wr_en;
  logic               sc_found;
  logic [IDX_W-1:0]   sc_idx;
  logic [31:0]        sc_size;
  logic               over;
  logic [31:0]        slot_ext, cnt_ext, ev_ext;

  lcb_mem #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (slot_r),
    .wr_data  (wr_data),
    .rd_addr  (addr_r),
    .rd_data_r(rd_data)
  );

  lcb_scan #(.IDX_W(IDX_W)) u_scan (
    .clk      (clk),
    .ctl      (ctl),
    .ent      (rd_data),
    .ent_valid(valid_r[rd_addr_r]),
    .ent_idx  (rd_addr_r),
    .key_low  (req_r.key_low),
    .key_high (req_r.key_high),
    .found_r  (sc_found),
    .idx_r    (sc_idx),
    .size_r   (sc_size)
  );

  // 33-bit compare so the sum never wraps
  assign over = ({1'b0, bytes_r} + {1'b0, req_r.image_size}) > {1'b0, budget_r};
  assign scan_last = rd_vld_r && (rd_addr_r == LAST);

  assign wr_data.key_low  = req_r.key_low;
  assign wr_data.key_high = req_r.key_high;
  assign wr_data.size     = insert_r ? req_r.image_size : esize_r;
  assign wr_data.stamp    = clock_r + 64'd1;
  assign wr_en            = (state_r == S_WRITE);

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    clock_nxt   = clock_r;
    count_nxt   = count_r;
    bytes_nxt   = bytes_r;
    evict_nxt   = evict_r;
    status_nxt  = status_r;
    hit_nxt     = hit_r;
    slot_nxt    = slot_r;
    esize_nxt   = esize_r;
    insert_nxt  = insert_r;
    full_ev_nxt = full_ev_r;
    addr_nxt    = addr_r;
    run_nxt     = 1'b0;
    ctl.clear    = 1'b0;
    ctl.step     = rd_vld_r;
    ctl.lru_mode = (state_r == S_EVSC);

    // read issue: one slot per cycle while a scan runs
    if (run_r) begin
      if (addr_r != LAST) begin
        addr_nxt = addr_r + IDX_W'(1);
        run_nxt  = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt   = S_CHECK;
          status_nxt  = 1'b0;
          hit_nxt     = 1'b0;
          slot_nxt    = '0;
          esize_nxt   = '0;
          insert_nxt  = 1'b0;
          full_ev_nxt = 1'b0;
          evict_nxt   = '0;
        end
      end
      S_CHECK: begin
        if ((req_r.opcode == lcb_pkg::OP_PUT) && (req_r.image_size > budget_r)) begin
          status_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          ctl.clear = 1'b1;
          addr_nxt  = '0;
          run_nxt   = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (scan_last) begin
          state_nxt = S_LDONE;
        end
      end
      S_LDONE: begin
        if (sc_found) begin
          hit_nxt   = 1'b1;
          slot_nxt  = sc_idx;
          esize_nxt = sc_size;
          state_nxt = (req_r.opcode == lcb_pkg::OP_GET ||
                       req_r.opcode == lcb_pkg::OP_PUT) ? S_WRITE : S_OUT;
        end else begin
          state_nxt = (req_r.opcode == lcb_pkg::OP_PUT) ? S_FIT : S_OUT;
        end
      end
      S_FIT: begin
        if (over) begin
          if (count_r == '0) begin
            status_nxt = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            ctl.clear = 1'b1;
            addr_nxt  = '0;
            run_nxt   = 1'b1;
            state_nxt = S_EVSC;
          end
        end else if (count_r != FULL) begin
          addr_nxt  = '0;
          state_nxt = S_FREE;
        end else begin
          full_ev_nxt = 1'b1;
          ctl.clear   = 1'b1;
          addr_nxt    = '0;
          run_nxt     = 1'b1;
          state_nxt   = S_EVSC;
        end
      end
      S_EVSC: begin
        if (scan_last) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        valid_nxt[sc_idx] = 1'b0;
        bytes_nxt = bytes_r - sc_size;
        count_nxt = count_r - CNT_W'(1);
        evict_nxt = evict_r + CNT_W'(1);
        if (full_ev_r) begin
          slot_nxt   = sc_idx;
          insert_nxt = 1'b1;
          state_nxt  = S_WRITE;
        end else begin
          state_nxt = S_FIT;
        end
      end
      S_FREE: begin
        if (!valid_r[addr_r]) begin
          slot_nxt   = addr_r;
          insert_nxt = 1'b1;
          state_nxt  = S_WRITE;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
        end
      end
      S_WRITE: begin
        clock_nxt = clock_r + 64'd1;
        if (insert_r) begin
          valid_nxt[slot_r] = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          bytes_nxt = bytes_r + req_r.image_size;
          esize_nxt = req_r.image_size;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      clock_r  <= '0;
      count_r  <= '0;
      bytes_r  <= '0;
      budget_r <= lcb_pkg::BUDGET_RESET;
      run_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      clock_r  <= clock_nxt;
      count_r  <= count_nxt;
      bytes_r  <= bytes_nxt;
      run_r    <= run_nxt;
      rd_vld_r <= run_r;
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_data;
    end
    evict_r   <= evict_nxt;
    status_r  <= status_nxt;
    hit_r     <= hit_nxt;
    slot_r    <= slot_nxt;
    esize_r   <= esize_nxt;
    insert_r  <= insert_nxt;
    full_ev_r <= full_ev_nxt;
    addr_r    <= addr_nxt;
    rd_addr_r <= addr_r;
  end

  // result word: output fields are masked to their port widths
  assign slot_ext = 32'(slot_r);
  assign cnt_ext  = 32'(count_r);
  assign ev_ext   = 32'(evict_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.status      = status_r;
  assign out_data.hit         = hit_r;
  assign out_data.slot        = slot_ext[lcb_pkg::SLOT_W-1:0];
  assign out_data.entry_size  = esize_r;
  assign out_data.entry_count = cnt_ext[lcb_pkg::COUNT_W-1:0];
  assign out_data.total_bytes = bytes_r;
  assign out_data.evictions   = ev_ext[lcb_pkg::COUNT_W-1:0];

  // occupancy counter tracks the valid bits exactly
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r))
    else $error("entry count out of step with valid bits");

  // an empty table holds no bytes
  a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (bytes_r == '0))
    else $error("bytes held with no entries");

  // an eviction always removes a valid victim
  a_evict_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT) |-> (sc_found && valid_r[sc_idx]))
    else $error("eviction without a valid victim");

  // an insert lands on a free slot
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && insert_r) |-> !valid_r[slot_r])
    else $error("insert over an occupied slot");

endmodule
`default_nettype wire

// ===== rtl/lcb_mem.sv =====
// Entry store: key, size and last-use stamp per slot, one write and one
// registered read port. Depends on lcb_pkg.
`default_nettype none
module lcb_mem #(
  parameter int unsigned ENTRIES = lcb_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = 6
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire lcb_pkg::entry_t wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output lcb_pkg::entry_t      rd_data_r
);

  lcb_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/lcb_scan.sv =====
// Shared scan unit: key match (first hit) or 64-bit stamp minimum (lowest
// slot on ties), one entry per step. Depends on lcb_pkg.
`default_nettype none
module lcb_scan #(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic               clk,
  input  wire lcb_pkg::scan_ctl_t ctl,
  input  wire lcb_pkg::entry_t    ent,
  input  wire logic               ent_valid,
  input  wire logic [IDX_W-1:0]   ent_idx,
  input  wire logic [63:0]        key_low,
  input  wire logic [63:0]        key_high,
  output logic                    found_r,
  output logic [IDX_W-1:0]        idx_r,
  output logic [31:0]             size_r
);

  logic [63:0] best_r;
  logic        take;

  always_comb begin
    if (ctl.lru_mode) begin
      take = ent_valid && (!found_r || (ent.stamp < best_r));
    end else begin
      take = ent_valid && !found_r &&
             (ent.key_low == key_low) && (ent.key_high == key_high);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (ctl.step && take) begin
      found_r <= 1'b1;
      idx_r   <= ent_idx;
      size_r  <= ent.size;
      best_r  <= ent.stamp;
    end
  end

endmodule
`default_nettype wire

// ===== tb/lcb_checker.sv =====
// Checker for the LRU cache core: watches the request and result channels,
// predicts each result word from its own table model and compares fields.
// Depends on lcb_pkg.
`timescale 1ns / 1ps
module lcb_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire lcb_pkg::req_t in_data,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire lcb_pkg::rsp_t out_data,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  localparam int N = 64;

  logic [31:0] budget;
  logic        occ [N];
  logic [63:0] klo_m [N];
  logic [63:0] khi_m [N];
  logic [31:0] sz_m [N];
  logic [63:0] stamp_m [N];
  logic [63:0] clock_m;
  logic [6:0]  cnt_m;
  logic [31:0] bytes_m;
  lcb_pkg::rsp_t expected_q [$];

  function automatic int find_key(logic [63:0] lo, logic [63:0] hi);
    for (int i = 0; i < N; i++)
      if (occ[i] && klo_m[i] == lo && khi_m[i] == hi) return i;
    return -1;
  endfunction

  function automatic int first_open();
    for (int i = 0; i < N; i++)
      if (!occ[i]) return i;
    return -1;
  endfunction

  function automatic bit drop_lru();
    int v;
    v = -1;
    for (int i = 0; i < N; i++)
      if (occ[i] && (v < 0 || stamp_m[i] < stamp_m[v])) v = i;
    if (v < 0) return 0;
    occ[v] = 0;
    bytes_m = bytes_m - sz_m[v];
    cnt_m = cnt_m - 7'd1;
    return 1;
  endfunction

  function automatic lcb_pkg::rsp_t cache_access(lcb_pkg::req_t r);
    lcb_pkg::rsp_t o;
    int    idx;
    logic [6:0] ev;
    o = '0;
    ev = '0;
    if (r.opcode != lcb_pkg::OP_PUT) begin
      idx = find_key(r.key_low, r.key_high);
      if (idx >= 0) begin
        o.hit = 1; o.slot = idx[5:0]; o.entry_size = sz_m[idx];
        if (r.opcode == lcb_pkg::OP_GET) begin
          clock_m = clock_m + 64'd1; stamp_m[idx] = clock_m;
        end
      end
    end else if (r.image_size > budget) begin
      o.status = 1;
    end else begin
      idx = find_key(r.key_low, r.key_high);
      if (idx >= 0) begin
        o.hit = 1; o.slot = idx[5:0]; o.entry_size = sz_m[idx];
        clock_m = clock_m + 64'd1; stamp_m[idx] = clock_m;
      end else begin
        // 33-bit sums so an over-budget total never wraps
        while ({1'b0, bytes_m} + {1'b0, r.image_size} > {1'b0, budget}) begin
          if (!drop_lru()) break;
          ev++;
        end
        if ({1'b0, bytes_m} + {1'b0, r.image_size} > {1'b0, budget}) o.status = 1;
        else begin
          idx = first_open();
          if (idx < 0 && drop_lru()) begin
            ev++; idx = first_open();
          end
          if (idx < 0) o.status = 1;
          else begin
            klo_m[idx] = r.key_low; khi_m[idx] = r.key_high;
            sz_m[idx] = r.image_size;
            clock_m = clock_m + 64'd1; stamp_m[idx] = clock_m;
            occ[idx] = 1; cnt_m++; bytes_m = bytes_m + r.image_size;
            o.slot = idx[5:0]; o.entry_size = r.image_size;
          end
        end
      end
    end
    o.entry_count = cnt_m;
    o.total_bytes = bytes_m;
    o.evictions = ev;
    return o;
  endfunction

  always @(posedge clk) begin
    lcb_pkg::rsp_t e;
    if (!rst_n) begin
      budget = lcb_pkg::BUDGET_RESET;
      for (int i = 0; i < N; i++) occ[i] = 0;
      clock_m = 0; cnt_m = 0; bytes_m = 0;
      expected_q.delete();
      fail_count = 0; result_count = 0;
    end else begin
      if (cfg_we) budget = cfg_wdata;
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", out_data);
        end else begin
          e = expected_q.pop_front();
          if (out_data !== e) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("word %0d: exp st%0d h%0d sl%0d sz%0d n%0d tot%0d ev%0d",
                result_count, e.status, e.hit, e.slot, e.entry_size, e.entry_count,
                e.total_bytes, e.evictions);
              $display("word %0d: got st%0d h%0d sl%0d sz%0d n%0d tot%0d ev%0d",
                result_count, out_data.status, out_data.hit, out_data.slot,
                out_data.entry_size, out_data.entry_count, out_data.total_bytes,
                out_data.evictions);
            end
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(cache_access(in_data));
    end
    pending_count = expected_q.size();
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top for lru_cache_with_byte_budget_core: drives requests, budget
// writes and result-side stalls; lcb_checker does the prediction and compare.
// Depends on lcb_pkg, the core and tb/lcb_checker.sv.
`timescale 1ns / 1ps
module tb;

  logic  clk = 0;
  logic  rst_n = 0;
  logic  in_valid = 0;
  logic  in_stall;
  lcb_pkg::req_t in_data = '0;
  logic  out_valid;
  logic  out_stall = 0;
  lcb_pkg::rsp_t out_data;
  logic  cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  int    fail_count, pending_count, result_count;
  int    cycle = 0;
  int    sent = 0;
  bit    calm = 0;       // last part of the run: no idling on either side
  bit    hold_long = 0;  // receiver holds off for a long stretch
  logic [63:0] key_pool_lo [16];
  logic [63:0] key_pool_hi [16];

  always #1 clk = ~clk;

  lru_cache_with_byte_budget_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_wdata);

  lcb_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_wdata, .fail_count, .pending_count, .result_count);

  // Worst case is eviction-heavy puts plus stalls; cap generously.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 30000000) begin
      $display("timeout after %0d cycles", cycle);
      $display("lru_cache_with_byte_budget_core: mismatch");
      $finish;
    end
  end

  // Result side: random stall bursts, a long hold when asked, none when calm.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        for (n = 0; n < 600; n++) @(posedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // One request word; waits for acceptance, then maybe an idle burst.
  task automatic send_word(logic [1:0] op, logic [63:0] lo, logic [63:0] hi,
                           logic [31:0] sz);
    in_data <= '{opcode: op, key_low: lo, key_high: hi, image_size: sz};
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain_and_set_budget(logic [31:0] b);
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);  // settling margin; a put finishes its scans before its result word
    cfg_we <= 1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_word(logic [31:0] szmax);
    int k;
    logic [1:0] op;
    logic [31:0] sz;
    k = $urandom_range(0, 15);
    op = ($urandom_range(0, 9) < 5) ? lcb_pkg::OP_PUT : 2'($urandom_range(0, 3));
    sz = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, szmax);
    if ($urandom_range(0, 9) == 0)
      send_word(op, {$urandom(), $urandom()}, {$urandom(), $urandom()}, sz);
    else
      send_word(op, key_pool_lo[k], key_pool_hi[k], sz);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      key_pool_lo[i] = {$urandom(), $urandom()};
      key_pool_hi[i] = {$urandom(), $urandom()};
    end
    key_pool_lo[0] = '0; key_pool_hi[0] = '0;
    key_pool_lo[1] = '1; key_pool_hi[1] = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: misses, puts, hits, touches, too-big, alternate opcode.
    send_word(lcb_pkg::OP_HAS, '0, '0, '0);
    send_word(lcb_pkg::OP_PUT, '0, '0, '0);
    send_word(lcb_pkg::OP_PUT, '1, '1, 32'd16777216);
    send_word(lcb_pkg::OP_PUT, 64'd5, 64'd5, 32'd1);
    send_word(lcb_pkg::OP_PUT, 64'd6, 64'd6, 32'd16777217);
    send_word(lcb_pkg::OP_HAS, '1, '1, '1);
    send_word(lcb_pkg::OP_GET, '0, '0, '0);
    send_word(lcb_pkg::OP_ALT, '0, '0, '0);
    send_word(lcb_pkg::OP_PUT, '0, '0, 32'hFFFF_FFFF);
    send_word(lcb_pkg::OP_PUT, '0, '0, 32'd7);
    send_word(lcb_pkg::OP_GET, 64'd5, 64'd5, '0);
    drain_and_set_budget(32'hFFFF_FFFF);
    send_word(lcb_pkg::OP_PUT, 64'd7, 64'd7, 32'hFFFF_FFFF);
    send_word(lcb_pkg::OP_PUT, 64'd8, 64'd8, 32'd1);
    drain_and_set_budget(32'd1);
    send_word(lcb_pkg::OP_PUT, 64'd9, 64'd9, 32'd1);
    send_word(lcb_pkg::OP_PUT, 64'd10, 64'd10, 32'd0);
    send_word(lcb_pkg::OP_PUT, 64'd11, 64'd11, 32'd2);

    // Slot-full pressure: tiny entries exceed 64 slots; long receiver hold.
    drain_and_set_budget(32'd1000);
    hold_long = 1;
    for (int i = 0; i < 80; i++)
      send_word($urandom_range(0, 3) == 0 ? lcb_pkg::OP_GET : lcb_pkg::OP_PUT,
                {32'd0, i[31:0] % 70}, 64'd3, $urandom_range(0, 12));

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: drain_and_set_budget(32'd100);
        1: drain_and_set_budget(32'd4096);
        2: drain_and_set_budget(32'd1);
        3: drain_and_set_budget(32'hFFFF_FFFF);
        default: drain_and_set_budget(32'd16777216);
      endcase
      if (phase == 4) calm = 1;
      for (int i = 0; i < 260; i++)
        random_word(phase == 2 ? 32'd1 : phase == 0 ? 32'd60 : 32'd3000);
    end

    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests, checked %0d results across six budgets incl. 1 and max,",
             sent, result_count);
    $display("with eviction, full-table and oversize puts plus a long output hold");
    if (fail_count == 0)
      $display("lru_cache_with_byte_budget_core: match");
    else
      $display("lru_cache_with_byte_budget_core: mismatch");
    $finish;
  end
endmodule
